@@ src/assert_macros.svh @@
// Assertion macros for the checker file ilc_chk.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ilc_pkg.sv @@
// Shared types and constants of the inode location calculator.
// No dependencies.
`default_nettype none

package ilc_pkg;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INODE_ZERO  = 2'd1;
    localparam logic [1:0] ST_GROUP_RANGE = 2'd2;
    localparam logic [1:0] ST_SIZE_OVER   = 2'd3;

    localparam logic [1:0] CFG_INODES_PER_GROUP = 2'd0;
    localparam logic [1:0] CFG_LOG_BLOCK_SIZE   = 2'd1;
    localparam logic [1:0] CFG_INODE_SIZE       = 2'd2;
    localparam logic [1:0] CFG_GROUP_COUNT      = 2'd3;

    localparam int unsigned BSIZE_W          = 17;
    localparam int unsigned BASE_BLOCK_BYTES = 1024;
    localparam logic [2:0]  MAX_LOG_BLOCK    = 3'd6;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] group_index;
        logic [31:0] blk_addr;
        logic [15:0] byte_offset;
    } t_res;

endpackage

`default_nettype wire

@@ src/ilc_if.sv @@
// Stream interfaces of the inode location calculator: request and result.
// No dependencies.
`default_nettype none

interface ilc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [9:0]  load_group;
    logic [31:0] table_start_block;
    logic [31:0] ino_num;

    modport source (output valid, func, load_group, table_start_block, ino_num,
                    input ready);
    modport sink   (input valid, func, load_group, table_start_block, ino_num,
                    output ready);
endinterface

interface ilc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] group_index;
    logic [31:0] blk_addr;
    logic [15:0] byte_offset;

    modport source (output valid, status, group_index, blk_addr, byte_offset,
                    input ready);
    modport sink   (input valid, status, group_index, blk_addr, byte_offset,
                    output ready);
endinterface

`default_nettype wire

@@ src/ilc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module ilc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/ilc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// No dependencies.
`default_nettype none

module ilc_div #(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_div,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic      [NW-1:0] o_quo,
    output logic      [DW-1:0] o_rem,
    output logic      [SW-1:0] o_side
);

    logic          r_v    [NW];
    logic [NW-1:0] r_num  [NW];
    logic [DW-1:0] r_rem  [NW];
    logic [DW-1:0] r_div  [NW];
    logic [SW-1:0] r_side [NW];

    for (genvar g = 0; g < NW; g++) begin : g_st
        logic          p_v;
        logic [NW-1:0] p_num;
        logic [DW-1:0] p_rem;
        logic [DW-1:0] p_div;
        logic [SW-1:0] p_side;
        logic [DW:0]   tmp;
        logic [DW:0]   diff;
        logic          ge;

        if (g == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_num  = i_num;
            assign p_rem  = '0;
            assign p_div  = i_div;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[g-1];
            assign p_num  = r_num[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_div  = r_div[g-1];
            assign p_side = r_side[g-1];
        end

        // shift in the next numerator bit, subtract when it fits
        assign tmp  = {p_rem, p_num[NW-1]};
        assign diff = tmp - {1'b0, p_div};
        assign ge   = tmp >= {1'b0, p_div};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[g]  <= {p_num[NW-2:0], ge};
                r_rem[g]  <= ge ? diff[DW-1:0] : tmp[DW-1:0];
                r_div[g]  <= p_div;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_num[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

`default_nettype wire

@@ src/inode_location_calculator.sv @@
// Inode location calculator. Pipeline from the accepting edge to result valid:
// 32 stages of group division (the first captures the request), one table
// read stage, 32 stages of block division, one output register. Throughput one
// transaction per cycle, held while the skid entry is full. Synchronous active-low
// reset clears control state; the group table is not cleared. The per-block inode
// count is recomputed after reset and after each configuration write.
`default_nettype none

module inode_location_calculator import ilc_pkg::*; #(
    parameter int GROUP_TABLE_DEPTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    ilc_in_if.sink           i_in,
    ilc_out_if.source        o_out
);

    localparam int AW   = (GROUP_TABLE_DEPTH > 1) ? $clog2(GROUP_TABLE_DEPTH) : 1;
    localparam int SW1  = 3 + AW + 32;
    localparam int SW2  = 3 + 32 + 32;
    localparam int CNTW = $clog2(BSIZE_W + 1);

    // configuration
    logic [31:0] r_ipg;
    logic [2:0]  r_lbs;
    logic [10:0] r_isz;
    logic [10:0] r_gc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipg <= 32'd8192;
            r_lbs <= 3'd0;
            r_isz <= 11'd128;
            r_gc  <= 11'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INODES_PER_GROUP: r_ipg <= i_cfg_data;
                CFG_LOG_BLOCK_SIZE:   r_lbs <= i_cfg_data[2:0];
                CFG_INODE_SIZE:       r_isz <= i_cfg_data[10:0];
                CFG_GROUP_COUNT:      r_gc  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    logic [2:0]         lg;
    logic [BSIZE_W-1:0] bsize;
    logic               size_over;

    assign lg        = (r_lbs > MAX_LOG_BLOCK) ? MAX_LOG_BLOCK : r_lbs;
    assign bsize     = BSIZE_W'(BASE_BLOCK_BYTES) << lg;
    assign size_over = (r_isz == 11'd0) || (BSIZE_W'(r_isz) > bsize);

    // inodes per block, one quotient bit a cycle; after reset, ready before any
    // request reaches the block division
    logic               r_pb_load;
    logic [CNTW-1:0]    r_pb_cnt;
    logic [BSIZE_W-1:0] r_pb_num;
    logic [10:0]        r_pb_rem;
    logic [11:0]        pb_tmp;
    logic [11:0]        pb_diff;
    logic               pb_ge;

    assign pb_tmp  = {r_pb_rem, r_pb_num[BSIZE_W-1]};
    assign pb_diff = pb_tmp - {1'b0, r_isz};
    assign pb_ge   = pb_tmp >= {1'b0, r_isz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb_load <= 1'b1;
            r_pb_cnt  <= '0;
        end else if (i_cfg_we) begin
            r_pb_load <= 1'b1;
        end else if (r_pb_load) begin
            r_pb_load <= 1'b0;
            r_pb_cnt  <= CNTW'(BSIZE_W);
        end else if (r_pb_cnt != '0) begin
            r_pb_cnt <= r_pb_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pb_load) begin
            r_pb_num <= bsize;
            r_pb_rem <= '0;
        end else if (r_pb_cnt != '0) begin
            r_pb_num <= {r_pb_num[BSIZE_W-2:0], pb_ge};
            r_pb_rem <= pb_ge ? pb_diff[10:0] : pb_tmp[10:0];
        end
    end

    // pipeline advance: hold everything only while the skid entry is full
    logic en;
    logic r_skid_v;

    assign en         = !r_skid_v;
    assign i_in.ready = en;

    logic        in_acc;
    logic [31:0] lgrp32;
    logic        in_lok;

    assign in_acc = i_in.valid && en;
    assign lgrp32 = 32'(i_in.load_group);
    assign in_lok = lgrp32 < 32'(GROUP_TABLE_DEPTH);

    // group division: (n-1) / inodes per group
    logic           d1_v;
    logic [31:0]    d1_q;
    logic [31:0]    d1_r;
    logic [SW1-1:0] d1_s;

    ilc_div #(.NW(32), .DW(32), .SW(SW1)) u_div_grp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (in_acc),
        .i_num   (i_in.ino_num - 32'd1),
        .i_div   (r_ipg),
        .i_side  ({i_in.func, in_lok, (i_in.ino_num == 32'd0),
                   lgrp32[AW-1:0], i_in.table_start_block}),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_rem   (d1_r),
        .o_side  (d1_s)
    );

    logic          d1_func;
    logic          d1_lok;
    logic          d1_nz;
    logic [AW-1:0] d1_addr;
    logic [31:0]   d1_start;

    assign {d1_func, d1_lok, d1_nz, d1_addr, d1_start} = d1_s;

    // loads write and lookups read at the same stage, so table accesses
    // follow transaction order without forwarding
    logic [31:0] ram_rdata;

    ilc_ram #(.WIDTH(32), .DEPTH(GROUP_TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (en && d1_v && !d1_func && d1_lok),
        .i_waddr (d1_addr),
        .i_wdata (d1_start),
        .i_re    (en),
        .i_raddr (d1_q[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    logic        r_a_v;
    logic [31:0] r_a_grp;
    logic [31:0] r_a_idx;
    logic        r_a_func;
    logic        r_a_lok;
    logic        r_a_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_grp  <= d1_q;
            r_a_idx  <= d1_r;
            r_a_func <= d1_func;
            r_a_lok  <= d1_lok;
            r_a_nz   <= d1_nz;
        end
    end

    // block division: index / inodes per block
    logic               d2_v;
    logic [31:0]        d2_q;
    logic [BSIZE_W-1:0] d2_r;
    logic [SW2-1:0]     d2_s;

    ilc_div #(.NW(32), .DW(BSIZE_W), .SW(SW2)) u_div_blk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_v),
        .i_num   (r_a_idx),
        .i_div   (r_pb_num),
        .i_side  ({r_a_func, r_a_lok, r_a_nz, r_a_grp, ram_rdata}),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_rem   (d2_r),
        .o_side  (d2_s)
    );

    logic        d2_func;
    logic        d2_lok;
    logic        d2_nz;
    logic [31:0] d2_grp;
    logic [31:0] d2_start;
    logic [27:0] off_full;
    logic        grp_bad;
    t_res        res;

    assign {d2_func, d2_lok, d2_nz, d2_grp, d2_start} = d2_s;
    assign off_full = d2_r * r_isz;
    assign grp_bad  = (d2_grp >= 32'(r_gc)) || (d2_grp >= 32'(GROUP_TABLE_DEPTH));

    always_comb begin
        res = '0;
        if (!d2_func) begin
            res.status = d2_lok ? ST_OK : ST_GROUP_RANGE;
        end else if (d2_nz) begin
            res.status = ST_INODE_ZERO;
        end else if (r_ipg == 32'd0) begin
            res.status = ST_GROUP_RANGE;
        end else if (grp_bad) begin
            res.status      = ST_GROUP_RANGE;
            res.group_index = d2_grp;
        end else if (size_over) begin
            res.status      = ST_SIZE_OVER;
            res.group_index = d2_grp;
        end else begin
            res.status      = ST_OK;
            res.group_index = d2_grp;
            res.blk_addr    = d2_start + d2_q;
            res.byte_offset = off_full[15:0];
        end
    end

    // output register with one skid entry
    logic r_out_v;
    t_res r_out;
    t_res r_skid;
    logic take;

    assign take = r_out_v && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (take) begin
                    r_skid_v <= 1'b0;
                end
            end else if (d2_v) begin
                if (r_out_v && !take) begin
                    r_skid_v <= 1'b1;
                end else begin
                    r_out_v <= 1'b1;
                end
            end else if (take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (d2_v) begin
            if (r_out_v && !take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.status      = r_out.status;
    assign o_out.group_index = r_out.group_index;
    assign o_out.blk_addr    = r_out.blk_addr;
    assign o_out.byte_offset = r_out.byte_offset;

endmodule

`default_nettype wire

@@ src/ilc_chk.sv @@
// Port-level checker for the inode location calculator, bound to the top.
// Depends on ilc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ilc_chk import ilc_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_status,
    input wire logic [31:0] i_group_index,
    input wire logic [31:0] i_blk_addr,
    input wire logic [15:0] i_byte_offset
);

    `AST_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_group_index) && $stable(i_blk_addr) && $stable(i_byte_offset), "stalled result changed")

    `AST_IMPL(a_zero_fields, i_clk, i_rst_n, i_out_valid && i_status == ST_INODE_ZERO, i_group_index == 32'd0 && i_blk_addr == 32'd0 && i_byte_offset == 16'd0, "inode zero result has nonzero fields")

    `AST_IMPL(a_err_fields, i_clk, i_rst_n, i_out_valid && (i_status == ST_GROUP_RANGE || i_status == ST_SIZE_OVER), i_blk_addr == 32'd0 && i_byte_offset == 16'd0, "error result carries an address")

    `AST_IMPL(a_reset_empty, i_clk, i_rst_n, !$past(i_rst_n), !i_out_valid, "result valid right after reset")

    `AST_IMPL(a_stall_full, i_clk, i_rst_n, !i_in_ready, i_out_valid, "request stalled with no result waiting")

endmodule

bind inode_location_calculator ilc_chk u_ilc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_group_index (o_out.group_index),
    .i_blk_addr    (o_out.blk_addr),
    .i_byte_offset (o_out.byte_offset)
);

`default_nettype wire

@@ sim/inode_location_calculator_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the inode location calculator: a scoreboard class
// predicts each result. Depends on ilc_pkg, ilc_if and the block.
module inode_location_calculator_test;
    import ilc_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int PIPE_LATENCY = 66;
    localparam int RECALC_CYCLES = 18;

    class location_scoreboard;
        logic [31:0] ino_per_grp = 32'd8192;
        logic [2:0]  blk_shift = 3'd0;
        logic [10:0] rec_bytes = 11'd128;
        logic [10:0] group_count = 11'd1;
        logic [31:0] table_starts [TABLE_DEPTH];
        bit          written [TABLE_DEPTH];
        t_res        pending [$];
        int          errors = 0;

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_INODES_PER_GROUP: ino_per_grp = data;
                CFG_LOG_BLOCK_SIZE:   blk_shift = data[2:0];
                CFG_INODE_SIZE:       rec_bytes = data[10:0];
                CFG_GROUP_COUNT:      group_count = data[10:0];
                default: ;
            endcase
        endfunction

        function t_res locate(logic [31:0] n);
            t_res        r;
            logic [31:0] grp, idx, per_block;
            int unsigned lg, bsize;
            r = '0;
            r.status = ST_OK;
            if (n == 0) begin
                r.status = ST_INODE_ZERO;
                return r;
            end
            if (ino_per_grp == 0) begin
                r.status = ST_GROUP_RANGE;
                return r;
            end
            grp = (n - 1) / ino_per_grp;
            idx = (n - 1) % ino_per_grp;
            r.group_index = grp;
            if (grp >= group_count || grp >= TABLE_DEPTH) begin
                r.status = ST_GROUP_RANGE;
                return r;
            end
            lg = (blk_shift > MAX_LOG_BLOCK) ? MAX_LOG_BLOCK : blk_shift;
            bsize = BASE_BLOCK_BYTES << lg;
            if (rec_bytes == 0 || rec_bytes > bsize) begin
                r.status = ST_SIZE_OVER;
                return r;
            end
            per_block = bsize / rec_bytes;
            r.blk_addr = table_starts[grp] + idx / per_block;
            r.byte_offset = 16'((idx % per_block) * rec_bytes);
            return r;
        endfunction

        // Group a locate would read from the table, or -1 if none.
        function int table_group(logic [31:0] n);
            logic [31:0] grp;
            if (n == 0 || ino_per_grp == 0) return -1;
            grp = (n - 1) / ino_per_grp;
            if (grp >= group_count || grp >= TABLE_DEPTH) return -1;
            return int'(grp);
        endfunction

        function void note_request(logic func, logic [9:0] grp, logic [31:0] start,
                                   logic [31:0] n);
            t_res r;
            if (func == 1'b0) begin
                r = '0;
                r.status = ST_OK;
                table_starts[grp] = start;
                written[grp] = 1'b1;
                pending.push_back(r);
            end else begin
                pending.push_back(locate(n));
            end
        endfunction

        function void check_result(t_res got);
            t_res exp;
            if (pending.size() == 0) begin
                $error("unexpected result: status %0d group %0d", got.status, got.group_index);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.group_index !== exp.group_index) begin
                $error("group_index: expected %0h, got %0h", exp.group_index, got.group_index);
                errors++;
            end
            if (got.blk_addr !== exp.blk_addr) begin
                $error("blk_addr: expected %0h, got %0h", exp.blk_addr, got.blk_addr);
                errors++;
            end
            if (got.byte_offset !== exp.byte_offset) begin
                $error("byte_offset: expected %0h, got %0h", exp.byte_offset, got.byte_offset);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    bit          no_gaps;

    ilc_in_if  req_ch ();
    ilc_out_if res_ch ();

    location_scoreboard sb;

    inode_location_calculator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (req_ch),
        .o_out       (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver stall pattern, with stall-free stretches.
    initial begin : ready_driver
        int hold;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 299) == 0) hold = $urandom_range(50, 200);
            if (hold > 0) begin
                hold--;
                res_ch.ready = 1'b1;
            end else begin
                res_ch.ready = (gap_len() == 0);
                if (!res_ch.ready && $urandom_range(0, 9) == 0)
                    repeat ($urandom_range(10, 40)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.status = res_ch.status;
            got.group_index = res_ch.group_index;
            got.blk_addr = res_ch.blk_addr;
            got.byte_offset = res_ch.byte_offset;
            sb.check_result(got);
        end
    end

    task automatic send(logic func, logic [9:0] grp, logic [31:0] start, logic [31:0] n);
        int gap;
        @(negedge i_clk);
        req_ch.valid = 1'b1;
        req_ch.func = func;
        req_ch.load_group = grp;
        req_ch.table_start_block = start;
        req_ch.ino_num = n;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(func, grp, start, n);
        gap = gap_len();
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic load_group(logic [9:0] grp, logic [31:0] start);
        send(1'b0, grp, start, $urandom);
    endtask

    // Fill the table entry first so no unwritten entry is ever read.
    task automatic locate_inode(logic [31:0] n);
        int g;
        g = sb.table_group(n);
        if (g >= 0 && !sb.written[g]) load_group(g[9:0], $urandom);
        send(1'b1, 10'($urandom), $urandom, n);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] ipg, logic [2:0] lg, logic [10:0] isz,
                             logic [10:0] gc);
        logic [31:0] vals [4];
        vals = '{ipg, {29'd0, lg}, {21'd0, isz}, {21'd0, gc}};
        drain();
        foreach (vals[k]) begin
            @(negedge i_clk);
            i_cfg_we = 1'b1;
            i_cfg_index = k[1:0];
            i_cfg_data = vals[k];
            sb.write_reg(k[1:0], vals[k]);
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        // hold off while the per-block count is recomputed
        repeat (RECALC_CYCLES + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_inode();
        int          r;
        logic [63:0] grp, idx;
        r = $urandom_range(0, 99);
        if (r < 70 && sb.ino_per_grp != 0) begin
            grp = $urandom_range(0, sb.group_count + 1);
            idx = (sb.ino_per_grp > 1) ? {$urandom, $urandom} % sb.ino_per_grp : 0;
            return 32'(grp * sb.ino_per_grp + idx + 1);
        end
        if (r < 90) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            default: return sb.ino_per_grp;
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] ipg;
        int          t;
        sb = new();
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_INODES_PER_GROUP;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.func = 1'b0;
        req_ch.load_group = '0;
        req_ch.table_start_block = '0;
        req_ch.ino_num = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (RECALC_CYCLES + 4) @(posedge i_clk);

        // directed: reset settings, table extremes, every status
        load_group(10'd0, 32'hFFFF_FFFF);
        load_group(10'd1023, 32'd0);
        load_group(10'd5, 32'h1234_5678);
        locate_inode(32'd0);
        locate_inode(32'd1);
        locate_inode(32'd8192);
        locate_inode(32'd8193);
        locate_inode(32'hFFFF_FFFF);
        configure(32'd1, 3'd0, 11'd128, 11'd1024);
        locate_inode(32'd1024);
        locate_inode(32'd1025);
        locate_inode(32'd6);
        configure(32'd0, 3'd7, 11'd1024, 11'd2047);
        locate_inode(32'd7);
        configure(32'hFFFF_FFFF, 3'd7, 11'd1024, 11'd2047);
        locate_inode(32'hFFFF_FFFF);
        configure(32'd100, 3'd0, 11'd2047, 11'd1024);
        locate_inode(32'd50);
        configure(32'd100, 3'd0, 11'd0, 11'd1024);
        locate_inode(32'd150);
        configure(32'd100, 3'd0, 11'd1025, 11'd0);
        locate_inode(32'd150);
        configure(32'd300, 3'd2, 11'd129, 11'd8);
        locate_inode(32'd299);
        locate_inode(32'd2400);
        locate_inode(32'd2401);

        for (int phase = 0; phase < 10; phase++) begin
            case ($urandom_range(0, 2))
                0: ipg = $urandom_range(1, 64);
                1: ipg = $urandom_range(1, 1 << 16);
                default: ipg = $urandom;
            endcase
            configure(ipg, 3'($urandom_range(0, 7)),
                      11'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(128, 1024)),
                      11'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(1, 1024)));
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 120; k++) begin
                if ($urandom_range(0, 99) < 25) begin
                    t = (sb.group_count != 0) ? $urandom_range(0, sb.group_count) : 0;
                    if ($urandom_range(0, 3) == 0 || t > 1023) t = $urandom_range(0, 1023);
                    load_group(t[9:0], $urandom);
                end else begin
                    locate_inode(pick_inode());
                end
            end
            no_gaps = 1'b0;
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
